>>> rtl/cst_pkg.sv
package cst_pkg;

    // Raw characters with a meaning to the tokenizer
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Result kinds
    localparam logic [2:0] KIND_BYTE   = 3'd0;
    localparam logic [2:0] KIND_FIELD  = 3'd1;
    localparam logic [2:0] KIND_RECORD = 3'd2;
    localparam logic [2:0] KIND_STATUS = 3'd3;
    localparam logic [2:0] KIND_ERROR  = 3'd4;

    // Error codes
    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_AFTER_QUOTE = 2'd1;
    localparam logic [1:0] ERR_STRAY_QUOTE = 2'd2;
    localparam logic [1:0] ERR_FIELD_COUNT = 2'd3;

    // Field parse mode
    typedef enum logic [2:0] {
        MODE_PLAIN      = 3'b001,
        MODE_QUOTED     = 3'b010,
        MODE_QUOTE_SEEN = 3'b100
    } mode_t;

    // One input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } item_t;

    // One result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  content_byte;
        logic        in_header;
        logic [7:0]  field_number;
        logic [31:0] rows_seen;
        logic        trailing_incomplete;
        logic [1:0]  fault_code;
    } result_t;

endpackage

>>> rtl/cst_core.sv
module cst_core #(
    parameter int MAX_FIELDS = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  cst_pkg::item_t  item,
    output logic            res_valid,
    output cst_pkg::result_t res
);
    import cst_pkg::*;

    localparam int FCW  = $clog2(MAX_FIELDS);
    localparam int CNTW = FCW + 1;
    localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_FIELDS);

    mode_t           mode_reg, mode_next;
    logic            skip_reg, skip_next;
    logic            fhb_reg, fhb_next;
    logic            begun_reg, begun_next;
    logic [FCW-1:0]  fc_reg, fc_next;
    logic [CNTW-1:0] hft_reg, hft_next;
    logic            hd_reg, hd_next;
    logic [31:0]     rc_reg, rc_next;
    logic            err_reg, err_next;
    logic [1:0]      code_reg, code_next;

    logic            act_content, act_field, act_record, act_err;
    logic [1:0]      act_code;
    logic [CNTW-1:0] count;
    logic [7:0]      b;
    logic            is_newline;

    assign b          = item.data_byte;
    assign is_newline = (b == CH_LF) || (b == CH_CR);
    assign count      = {1'b0, fc_reg} + CNTW'(1);

    // Decode the byte against the parse mode, then apply the chosen action
    always_comb
    begin
        mode_next   = mode_reg;
        skip_next   = skip_reg;
        fhb_next    = fhb_reg;
        begun_next  = begun_reg;
        fc_next     = fc_reg;
        hft_next    = hft_reg;
        hd_next     = hd_reg;
        rc_next     = rc_reg;
        err_next    = err_reg;
        code_next   = code_reg;
        act_content = 1'b0;
        act_field   = 1'b0;
        act_record  = 1'b0;
        act_err     = 1'b0;
        act_code    = ERR_NONE;

        res_valid               = 1'b0;
        res.kind                = KIND_BYTE;
        res.content_byte        = 8'd0;
        res.in_header           = !hd_reg;
        res.field_number        = 8'(fc_reg);
        res.rows_seen           = rc_reg;
        res.trailing_incomplete = 1'b0;
        res.fault_code          = ERR_NONE;

        if (step)
        begin
            if (item.end_of_input)
            begin
                // Report status, then return to the reset state
                res_valid               = 1'b1;
                res.kind                = KIND_STATUS;
                res.trailing_incomplete = (mode_reg != MODE_PLAIN) || begun_reg || fhb_reg;
                res.fault_code          = err_reg ? code_reg : ERR_NONE;
                mode_next  = MODE_PLAIN;
                skip_next  = 1'b0;
                fhb_next   = 1'b0;
                begun_next = 1'b0;
                fc_next    = '0;
                hft_next   = '0;
                hd_next    = 1'b0;
                rc_next    = '0;
                err_next   = 1'b0;
                code_next  = ERR_NONE;
            end
            else if (!err_reg)
            begin
                skip_next = 1'b0;
                if (!(skip_reg && (b == CH_LF)))
                begin
                    unique case (mode_reg)
                        MODE_QUOTED:
                        begin
                            if (b == CH_QUOTE)
                                mode_next = MODE_QUOTE_SEEN;
                            else
                                act_content = 1'b1;
                        end
                        MODE_QUOTE_SEEN:
                        begin
                            if (b == CH_QUOTE)
                            begin
                                mode_next   = MODE_QUOTED;
                                act_content = 1'b1;
                            end
                            else
                            begin
                                mode_next = MODE_PLAIN;
                                if (b == CH_COMMA)
                                    act_field = 1'b1;
                                else if (is_newline)
                                    act_record = 1'b1;
                                else
                                begin
                                    act_err  = 1'b1;
                                    act_code = ERR_AFTER_QUOTE;
                                end
                            end
                        end
                        default:
                        begin
                            if (b == CH_QUOTE)
                            begin
                                if (fhb_reg)
                                begin
                                    act_err  = 1'b1;
                                    act_code = ERR_STRAY_QUOTE;
                                end
                                else
                                begin
                                    mode_next  = MODE_QUOTED;
                                    begun_next = 1'b1;
                                end
                            end
                            else if (b == CH_COMMA)
                                act_field = 1'b1;
                            else if (is_newline)
                                act_record = 1'b1;
                            else
                                act_content = 1'b1;
                        end
                    endcase
                end

                // Field end, or a field count overflow
                if (act_field)
                begin
                    if (count >= MAX_CNT)
                    begin
                        act_err  = 1'b1;
                        act_code = ERR_FIELD_COUNT;
                    end
                    else
                    begin
                        res_valid  = 1'b1;
                        res.kind   = KIND_FIELD;
                        fc_next    = count[FCW-1:0];
                        fhb_next   = 1'b0;
                        begun_next = 1'b1;
                        mode_next  = MODE_PLAIN;
                    end
                end

                // Record end: header sets the field total, data rows must match it
                if (act_record)
                begin
                    if (hd_reg && (count != hft_reg))
                    begin
                        act_err  = 1'b1;
                        act_code = ERR_FIELD_COUNT;
                    end
                    else
                    begin
                        res_valid = 1'b1;
                        res.kind  = KIND_RECORD;
                        if (!hd_reg)
                        begin
                            hft_next = count;
                            hd_next  = 1'b1;
                        end
                        else if (rc_reg != '1)
                        begin
                            rc_next       = rc_reg + 32'd1;
                            res.rows_seen = rc_reg + 32'd1;
                        end
                        fc_next    = '0;
                        fhb_next   = 1'b0;
                        begun_next = 1'b0;
                        mode_next  = MODE_PLAIN;
                        skip_next  = (b == CH_CR);
                    end
                end

                if (act_content)
                begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_BYTE;
                    res.content_byte = b;
                    fhb_next         = 1'b1;
                    begun_next       = 1'b1;
                end

                // Latch the first error
                if (act_err)
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.fault_code = act_code;
                    err_next       = 1'b1;
                    code_next      = act_code;
                end
            end
        end
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_PLAIN;
            skip_reg  <= 1'b0;
            fhb_reg   <= 1'b0;
            begun_reg <= 1'b0;
            fc_reg    <= '0;
            hft_reg   <= '0;
            hd_reg    <= 1'b0;
            rc_reg    <= '0;
            err_reg   <= 1'b0;
            code_reg  <= ERR_NONE;
        end
        else
        begin
            mode_reg  <= mode_next;
            skip_reg  <= skip_next;
            fhb_reg   <= fhb_next;
            begun_reg <= begun_next;
            fc_reg    <= fc_next;
            hft_reg   <= hft_next;
            hd_reg    <= hd_next;
            rc_reg    <= rc_next;
            err_reg   <= err_next;
            code_reg  <= code_next;
        end
    end

    a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, fc_reg} < MAX_CNT))
        else $error("field counter beyond field limit");

    a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.end_of_input) |=> (fc_reg == '0) && !hd_reg && (rc_reg == '0) && !err_reg)
        else $error("end of input did not clear parser state");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg && !(step && item.end_of_input)) |=> err_reg)
        else $error("error flag dropped before end of input");

    a_hdr_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (hd_reg && !(step && item.end_of_input)) |=> hd_reg)
        else $error("header flag dropped before end of input");

    a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg && step && !item.end_of_input) |-> !res_valid)
        else $error("result produced while error latched");

endmodule

>>> rtl/csv_stream_tokenizer.sv
// Channel  Dir  tdata                                   tuser / tlast
// s_axis   in   [7:0] data_byte                         tlast = end_of_input
// m_axis   out  content_byte..fault_code (56 bits)      tuser[2:0] = kind
//
// One byte per cycle sustained unless the output stalls: an input register feeds
// the parser logic, whose result lands in an output register; both advance together.
// A stalled output holds the result and backs up into the input register.
// Reset (rst_n, asynchronous) returns the parser to the start of a header.
module csv_stream_tokenizer #(
    parameter int MAX_FIELDS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [7:0] content_byte, [8] in_header, [16:9] field_number,
                                   // [48:17] rows_seen, [49] trailing_incomplete,
                                   // [51:50] fault_code, [55:52] zero
    output logic [2:0]  m_tuser    // [2:0] kind
);
    import cst_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_reg;
    logic    adv;
    logic    step;
    logic    res_valid;
    result_t res;

    assign adv      = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && adv;
    assign s_tready = !in_valid_reg || adv;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.data_byte    <= s_tdata;
            in_item_reg.end_of_input <= s_tlast;
        end
    end

    cst_core #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (in_item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= step && res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {4'd0, out_reg.fault_code, out_reg.trailing_incomplete,
                       out_reg.rows_seen, out_reg.field_number, out_reg.in_header,
                       out_reg.content_byte};

endmodule
